// ----- hdl/keyed_value_table_top_assert.svh -----
// Assertion macros for the keyed value table checker.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef KEYED_VALUE_TABLE_TOP_ASSERT_SVH
`define KEYED_VALUE_TABLE_TOP_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define KVT_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("keyed value table assertion failed");

// Consequent checked in the cycle after the antecedent.
`define KVT_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("keyed value table assertion failed");

`endif

// ----- hdl/kvt_pkg.sv -----
// Package for the keyed value table: action and status codes and the
// request token that walks along the row of cells. No dependencies.
package kvt_pkg;

    localparam logic [1:0] ACT_INSERT   = 2'd0;
    localparam logic [1:0] ACT_UPDATE   = 2'd1;
    localparam logic [1:0] ACT_LOOKUP   = 2'd2;
    localparam logic [1:0] ACT_RESERVED = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_PRESENT = 2'd1;
    localparam logic [1:0] ST_UNKNOWN = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    typedef struct packed {
        logic               active;
        logic [1:0]         action;
        logic [31:0]        key;
        logic signed [63:0] new_value;
        logic               found;
        logic               placed;
        logic signed [63:0] value;
    } tok_t;

endpackage

// ----- hdl/keyed_value_table_top.sv -----
// Top level of the keyed value table: a row of kvt_cell slots and the
// result register. Depends on kvt_pkg and kvt_cell.
//
// Usage: a request (action, key, new_value) is taken at a rising edge where
// start is high and busy is low. Action 0 inserts the key with value zero
// in the lowest free slot, action 1 writes new_value to an existing key,
// action 2 reads the value of a key. Code 3 changes nothing.
// The request walks through the row one cell per cycle, and when it leaves
// the last cell, done is high for one cycle with status, read_value and
// entry_count. busy is high from the accepting edge until done rises, so
// no new request is taken while one is in the row; the length of the cell
// row sets the time between requests.
// A new request may be started in the cycle in which done is high.
// The receiver cannot hold results off; it must take them while done is high.
// Reset clears all valid flags, the entry count, busy and done; key and
// value storage is written before it is ever read.
module keyed_value_table_top
    import kvt_pkg::*;
#(
    parameter int ENTRIES = 128
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         action,
    input  logic [31:0]        key,
    input  logic signed [63:0] new_value,
    output logic               done,
    output logic [1:0]         status,
    output logic signed [63:0] read_value,
    output logic [7:0]         entry_count
);

    localparam int CW = $clog2(ENTRIES + 1);

    tok_t               chain [ENTRIES + 1];
    tok_t               last_tok;
    logic               accept;
    logic               busy_reg;
    logic               busy_next;
    logic               done_reg;
    logic               done_next;
    logic [1:0]         status_reg;
    logic [1:0]         status_next;
    logic signed [63:0] read_value_reg;
    logic signed [63:0] read_value_next;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;

    assign accept = start && !busy_reg;

    always_comb
    begin
        chain[0]           = '0;
        chain[0].active    = accept;
        chain[0].action    = action;
        chain[0].key       = key;
        chain[0].new_value = new_value;
    end

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        kvt_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .tok_in  (chain[i]),
            .tok_out (chain[i + 1])
        );
    end

    assign last_tok = chain[ENTRIES];

    always_comb
    begin
        busy_next       = busy_reg;
        done_next       = 1'b0;
        status_next     = status_reg;
        read_value_next = read_value_reg;
        count_next      = count_reg;
        if (accept)
        begin
            busy_next = 1'b1;
        end
        if (last_tok.active)
        begin
            busy_next       = 1'b0;
            done_next       = 1'b1;
            read_value_next = '0;
            case (last_tok.action)
                ACT_INSERT:
                begin
                    if (last_tok.found)
                    begin
                        status_next = ST_PRESENT;
                    end
                    else if (last_tok.placed)
                    begin
                        status_next = ST_OK;
                        count_next  = count_reg + CW'(1);
                    end
                    else
                    begin
                        status_next = ST_FULL;
                    end
                end
                ACT_UPDATE:
                begin
                    status_next = last_tok.found ? ST_OK : ST_UNKNOWN;
                end
                ACT_LOOKUP:
                begin
                    status_next = last_tok.found ? ST_OK : ST_UNKNOWN;
                    if (last_tok.found)
                    begin
                        read_value_next = last_tok.value;
                    end
                end
                default:
                begin
                    status_next = ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg     <= status_next;
        read_value_reg <= read_value_next;
    end

    assign busy        = busy_reg;
    assign done        = done_reg;
    assign status      = status_reg;
    assign read_value  = read_value_reg;
    assign entry_count = 8'(count_reg);

endmodule

// ----- hdl/kvt_cell.sv -----
// One slot of the keyed value table: valid flag, key and value, and the
// register that hands the request token on to the next cell. Uses kvt_pkg.
module kvt_cell
    import kvt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  tok_t tok_in,
    output tok_t tok_out
);

    logic               valid_reg;
    logic               valid_next;
    logic [31:0]        key_reg;
    logic [31:0]        key_next;
    logic signed [63:0] value_reg;
    logic signed [63:0] value_next;
    tok_t               tok_reg;
    tok_t               tok_next;

    always_comb
    begin
        tok_next   = tok_in;
        valid_next = valid_reg;
        key_next   = key_reg;
        value_next = value_reg;
        if (tok_in.active && !tok_in.found && !tok_in.placed)
        begin
            if (valid_reg && (key_reg == tok_in.key))
            begin
                tok_next.found = 1'b1;
                case (tok_in.action)
                    ACT_UPDATE: value_next = tok_in.new_value;
                    ACT_LOOKUP: tok_next.value = value_reg;
                    default: ;
                endcase
            end
            else if (!valid_reg && (tok_in.action == ACT_INSERT))
            begin
                // Valid slots always form a prefix, so the first free cell
                // is reached only after every occupied slot has been checked.
                tok_next.placed = 1'b1;
                valid_next      = 1'b1;
                key_next        = tok_in.key;
                value_next      = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        value_reg <= value_next;
    end

    assign tok_out = tok_reg;

endmodule

// ----- hdl/kvt_checker.sv -----
// Port-level checks for the keyed value table, bound to the top level.
// Depends on kvt_pkg and keyed_value_table_top_assert.svh.
`include "keyed_value_table_top_assert.svh"

module kvt_checker
    import kvt_pkg::*;
#(
    parameter int ENTRIES = 128
)
(
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               done,
    input logic [1:0]         status,
    input logic [7:0]         entry_count
);

    `KVT_ASSERT_NEXT(a_accept_sets_busy, start && !busy, busy)
    `KVT_ASSERT_NOW(a_done_not_busy, done, !busy)
    `KVT_ASSERT_NEXT(a_done_single, done, !done)
    `KVT_ASSERT_NOW(a_count_only_on_done, !done || (status != ST_OK), $stable(entry_count))
    `KVT_ASSERT_NOW(a_count_bound, 1'b1, (ENTRIES > 255) || (entry_count <= ENTRIES))

endmodule

bind keyed_value_table_top kvt_checker #(.ENTRIES(ENTRIES)) u_kvt_checker (.*);

// ----- test/tb_keyed_value_table_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for keyed_value_table_top: inserts, updates and lookups
// are checked against a predictor of the table kept in the bench. Depends on kvt_pkg.
module tb_keyed_value_table_top;
    import kvt_pkg::*;

    localparam int TABLE_SIZE     = 128;
    localparam int RANDOM_REQS    = 930;
    localparam int KEY_POOL_SIZE  = 144;
    localparam int WATCHDOG_LIMIT = 8 * (TABLE_SIZE + 16);

    typedef struct {
        logic [1:0]         op;
        logic [31:0]        k;
        logic signed [63:0] nv;
        int                 gap;
        bit                 drain_first;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [63:0] read_value;
        logic [7:0]         entry_count;
    } reply_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic [1:0]         action = '0;
    logic [31:0]        key = '0;
    logic signed [63:0] new_value = '0;
    logic               busy;
    logic               done;
    logic [1:0]         status;
    logic signed [63:0] read_value;
    logic [7:0]         entry_count;

    req_t   req_backlog[$];
    reply_t awaited_replies[$];
    int     n_issued = 0;
    int     n_taken = 0;
    int     fault_count = 0;
    int     quiet_cycles = 0;

    bit                 slot_used[TABLE_SIZE];
    logic [31:0]        slot_tag[TABLE_SIZE];
    logic signed [63:0] slot_val[TABLE_SIZE];
    int                 used_count = 0;

    keyed_value_table_top #(.ENTRIES(TABLE_SIZE)) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .action      (action),
        .key         (key),
        .new_value   (new_value),
        .done        (done),
        .status      (status),
        .read_value  (read_value),
        .entry_count (entry_count)
    );

    always #10 clk = ~clk;

    function automatic reply_t table_apply(logic [1:0] op, logic [31:0] k,
                                           logic signed [63:0] nv);
        reply_t r;
        int     hit;
        int     free_idx;
        r.status = ST_OK;
        r.read_value = '0;
        hit = -1;
        free_idx = -1;
        for (int i = TABLE_SIZE - 1; i >= 0; i--)
        begin
            if (slot_used[i] && slot_tag[i] == k)
                hit = i;
            if (!slot_used[i])
                free_idx = i;
        end
        case (op)
            ACT_INSERT:
            begin
                if (hit >= 0)
                    r.status = ST_PRESENT;
                else if (free_idx < 0)
                    r.status = ST_FULL;
                else
                begin
                    slot_used[free_idx] = 1'b1;
                    slot_tag[free_idx] = k;
                    slot_val[free_idx] = '0;
                    used_count++;
                end
            end
            ACT_UPDATE:
            begin
                if (hit < 0)
                    r.status = ST_UNKNOWN;
                else
                    slot_val[hit] = nv;
            end
            ACT_LOOKUP:
            begin
                if (hit < 0)
                    r.status = ST_UNKNOWN;
                else
                    r.read_value = slot_val[hit];
            end
            default:
            begin
            end
        endcase
        r.entry_count = used_count[7:0];
        return r;
    endfunction

    task automatic queue_req(logic [1:0] op, logic [31:0] k, logic signed [63:0] nv,
                             int gap, bit drain_first);
        req_t r;
        r.op = op;
        r.k = k;
        r.nv = nv;
        r.gap = gap;
        r.drain_first = drain_first;
        req_backlog.push_back(r);
    endtask

    task automatic flag_fault(string msg);
        fault_count++;
        if (fault_count <= 10)
            $display("%s", msg);
    endtask

    // Gaps are counted only in cycles where the block is not busy, so that
    // they shift the start of a request against the end of the previous one.
    always @(negedge clk)
    begin
        req_t nxt;
        if (rst_n && n_taken == n_issued)
        begin
            if (req_backlog.size() == 0)
                start <= 1'b0;
            else if (req_backlog[0].drain_first && awaited_replies.size() != 0)
                start <= 1'b0;
            else if (req_backlog[0].gap > 0)
            begin
                start <= 1'b0;
                if (!busy)
                    req_backlog[0].gap = req_backlog[0].gap - 1;
            end
            else
            begin
                nxt = req_backlog.pop_front();
                start <= 1'b1;
                action <= nxt.op;
                key <= nxt.k;
                new_value <= nxt.nv;
                n_issued <= n_issued + 1;
            end
        end
    end

    always @(posedge clk)
    begin
        reply_t want;
        reply_t got;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                awaited_replies.push_back(table_apply(action, key, new_value));
                n_taken <= n_taken + 1;
            end
            if (done)
            begin
                got.status = status;
                got.read_value = read_value;
                got.entry_count = entry_count;
                if (awaited_replies.size() == 0)
                    flag_fault($sformatf("unexpected result: status %0d value %0d count %0d",
                                         got.status, got.read_value, got.entry_count));
                else
                begin
                    want = awaited_replies.pop_front();
                    if (got.status !== want.status || got.read_value !== want.read_value ||
                        got.entry_count !== want.entry_count)
                        flag_fault($sformatf(
                            "mismatch: status %0d/%0d value %0d/%0d count %0d/%0d (exp/act)",
                            want.status, got.status, want.read_value, got.read_value,
                            want.entry_count, got.entry_count));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                quiet_cycles <= 0;
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("== FAIL ==");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        logic [31:0]        key_pool[KEY_POOL_SIZE];
        logic [1:0]         op;
        logic [31:0]        k;
        logic signed [63:0] nv;
        int                 pick;
        int                 gap;

        for (int i = 0; i < TABLE_SIZE; i++)
            slot_used[i] = 1'b0;
        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < KEY_POOL_SIZE; i++)
            key_pool[i] = $urandom;

        queue_req(ACT_LOOKUP, 32'h0, 64'sd0, 0, 1'b0);
        queue_req(ACT_UPDATE, 32'h0, 64'sd5, 2, 1'b0);
        queue_req(ACT_RESERVED, 32'h0, 64'sd0, 0, 1'b0);
        queue_req(ACT_INSERT, 32'h0, -64'sd1, 0, 1'b0);
        queue_req(ACT_INSERT, 32'h0, 64'sd0, 5, 1'b0);
        queue_req(ACT_LOOKUP, 32'h0, 64'sd0, 0, 1'b0);
        queue_req(ACT_UPDATE, 32'h0, 64'h7FFF_FFFF_FFFF_FFFF, 0, 1'b0);
        queue_req(ACT_LOOKUP, 32'h0, 64'sd0, 1, 1'b0);
        queue_req(ACT_UPDATE, 32'h0, 64'h8000_0000_0000_0000, 0, 1'b0);
        queue_req(ACT_LOOKUP, 32'h0, 64'sd0, 0, 1'b0);
        queue_req(ACT_INSERT, 32'hFFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF, 0, 1'b0);
        queue_req(ACT_LOOKUP, 32'hFFFF_FFFF, 64'sd0, 0, 1'b0);
        queue_req(ACT_UPDATE, 32'hFFFF_FFFF, -64'sd1, 3, 1'b0);
        queue_req(ACT_LOOKUP, 32'hFFFF_FFFF, 64'sd0, 0, 1'b0);
        queue_req(ACT_UPDATE, 32'h0, 64'sd0, 0, 1'b0);
        queue_req(ACT_LOOKUP, 32'h0, -64'sd1, 0, 1'b0);
        queue_req(ACT_RESERVED, 32'hFFFF_FFFF, -64'sd1, 0, 1'b0);
        queue_req(ACT_LOOKUP, 32'h1, 64'sd0, 0, 1'b0);
        queue_req(ACT_UPDATE, 32'h8000_0000, -64'sd1, 0, 1'b0);
        queue_req(ACT_INSERT, 32'hFFFF_FFFF, 64'sd0, 0, 1'b0);

        // Early on, inserts dominate so that the table fills and the full
        // case is exercised for most of the remaining run.
        for (int i = 0; i < RANDOM_REQS; i++)
        begin
            pick = $urandom_range(0, 99);
            if (i < 300)
                op = (pick < 60) ? ACT_INSERT : (pick < 75) ? ACT_UPDATE :
                     (pick < 94) ? ACT_LOOKUP : ACT_RESERVED;
            else
                op = (pick < 30) ? ACT_INSERT : (pick < 60) ? ACT_UPDATE :
                     (pick < 95) ? ACT_LOOKUP : ACT_RESERVED;
            if ($urandom_range(0, 99) < 92)
                k = key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
            else
                k = $urandom;
            case ($urandom_range(0, 9))
                0: nv = 64'h7FFF_FFFF_FFFF_FFFF;
                1: nv = 64'h8000_0000_0000_0000;
                2: nv = 64'sd0;
                3: nv = -64'sd1;
                default: nv = {$urandom, $urandom};
            endcase
            gap = 0;
            if (i < RANDOM_REQS * 85 / 100 && $urandom_range(0, 99) < 40)
                gap = $urandom_range(1, 13);
            queue_req(op, k, nv, gap, (i == 300 || i == 610));
        end

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (req_backlog.size() != 0 || n_taken != n_issued || awaited_replies.size() != 0)
            @(posedge clk);
        repeat (TABLE_SIZE + 8) @(posedge clk);

        fault_count += awaited_replies.size();
        if (fault_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/kvt_pkg.sv
hdl/kvt_cell.sv
hdl/keyed_value_table_top.sv
hdl/kvt_checker.sv
test/tb_keyed_value_table_top.sv
